// File: rtl/core/battery_level_monitor_assert.svh
// ----------------------------------------------------------------------------
// Battery level monitor assertion macros
// Concurrent assertion wrappers clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BATTERY_LEVEL_MONITOR_ASSERT_SVH
`define BATTERY_LEVEL_MONITOR_ASSERT_SVH

`ifndef ASSERT_OFF

// Check that a property holds at every rising edge out of reset
`define BLM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a condition never occurs out of reset
`define BLM_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`else

`define BLM_ASSERT(lbl, prop, msg)
`define BLM_ASSERT_NEVER(lbl, expr, msg)

`endif

`endif

// File: rtl/core/blm_pkg.sv
// ----------------------------------------------------------------------------
// Battery level monitor package
// Register indexes, field widths, level codes and sequencer states.
// ----------------------------------------------------------------------------
package blm_pkg;

  // Converter resolution and the shift that turns sample * full_scale into Q16.8
  localparam int unsigned ADC_BITS = 12;
  localparam int unsigned SCALE_SH = ADC_BITS - 8;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned SV_W = 24;
  localparam int unsigned MUL_A_W = 24;
  localparam int unsigned MUL_B_W = 16;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int unsigned IN_DATA_W = 16;
  localparam int unsigned OUT_DATA_W = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LOW_THR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CRIT_THR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_MV = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EMPTY_MV = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ADC_FS = 3'd5;

  // Register reset values
  localparam logic [15:0] RST_LOW_THR = 16'd3300;
  localparam logic [15:0] RST_CRIT_THR = 16'd3000;
  localparam logic [15:0] RST_FULL_MV = 16'd4200;
  localparam logic [15:0] RST_EMPTY_MV = 16'd3000;
  localparam logic [8:0] RST_ALPHA = 9'd26;
  localparam logic [15:0] RST_ADC_FS = 16'd6600;

  localparam logic [8:0] ALPHA_ONE = 9'd256;
  localparam logic [6:0] PCT_MAX = 7'd100;
  localparam logic [SV_W-1:0] SV_MAX = {SV_W{1'b1}};

  // Item kinds carried on tuser
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_FORCE = 1'b1;

  typedef enum logic [1:0] {
    LVL_NORMAL = 2'd0,
    LVL_LOW = 2'd1,
    LVL_CRIT = 2'd2
  } lvl_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCALE,
    ST_MIX_NEW,
    ST_MIX_OLD,
    ST_CLASSIFY,
    ST_PCT_SUB,
    ST_PCT_MUL,
    ST_DIV_CHK,
    ST_DIV,
    ST_OUT
  } fsm_e;

endpackage

// File: rtl/core/battery_level_monitor.sv
// A sample transaction passes the scale, filter, classify, percent and divide steps; a force
// transaction skips to the percent steps; a zero or saturated percentage skips the divide.
// No new transaction is taken until the last is loaded for output; the pace is set by the 8-step
// restoring divide and the single 24x16 multiplier shared by scale, filter and percent.
// Reset clears the smoothed voltage, sets the level to normal and loads the
// register defaults; the block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
// Battery level monitor
// Scales converter samples to millivolts, smooths them with an exponential
// average, classifies the level and reports a clamped charge percentage.
// ----------------------------------------------------------------------------
`include "battery_level_monitor_assert.svh"

module battery_level_monitor (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration write port
  input  logic                            cfg_we_i,
  input  logic [blm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [blm_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  // Input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata: adc_sample[11:0], forced_state[13:12], zero fill[15:14]
  input  logic [blm_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // tuser: kind[0]
  input  logic                            s_axis_tuser,
  // Output stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tdata: voltage_mv[15:0], percent[22:16], power_state[24:23],
  //        state_changed[25], battery_low[26], battery_critical[27], zero fill[31:28]
  output logic [blm_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
  import blm_pkg::*;

  // Configuration registers
  logic [15:0] low_thr_q, crit_thr_q, full_mv_q, empty_mv_q, adc_fs_q;
  logic [8:0]  alpha_q;

  // Sequencer and datapath registers
  fsm_e              state_q, state_d;
  lvl_e              lvl_q, lvl_d, prev_q, prev_d;
  logic [11:0]       sample_q, sample_d;
  logic [SV_W-1:0]   sv_q, sv_d;
  logic [SV_W-1:0]   nv_q, nv_d;
  logic [31:0]       acc_q, acc_d;
  logic [31:0]       rem_q, rem_d;
  logic [15:0]       den_q, den_d;
  logic [7:0]        quo_q, quo_d;
  logic [2:0]        cnt_q, cnt_d;

  // Output register
  logic              out_vld_q, out_vld_d;
  logic              out_load;
  logic [15:0]       out_mv_q;
  logic [6:0]        out_pct_q;
  lvl_e              out_lvl_q;
  logic              out_chg_q;

  // Shared multiplier
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p;
  logic [MUL_P_W-1:0] scaled;

  logic              in_hs;
  logic [8:0]        alpha_c;
  logic [SV_W-1:0]   empty_q8;
  logic [31:0]       div_sh;
  logic [SV_W-1:0]   sv_new;

  assign in_hs = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);

  assign alpha_c  = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;
  assign empty_q8 = {empty_mv_q, 8'd0};
  assign mul_p    = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
  assign scaled   = mul_p >> SCALE_SH;
  assign sv_new   = acc_q[31:8];
  // Divisor (full - empty) in Q16.8 shifted to the current quotient bit
  assign div_sh   = {8'd0, den_q, 8'd0} << cnt_q;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_thr_q  <= RST_LOW_THR;
      crit_thr_q <= RST_CRIT_THR;
      full_mv_q  <= RST_FULL_MV;
      empty_mv_q <= RST_EMPTY_MV;
      alpha_q    <= RST_ALPHA;
      adc_fs_q   <= RST_ADC_FS;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_LOW_THR:  low_thr_q  <= cfg_wdata_i;
        REG_CRIT_THR: crit_thr_q <= cfg_wdata_i;
        REG_FULL_MV:  full_mv_q  <= cfg_wdata_i;
        REG_EMPTY_MV: empty_mv_q <= cfg_wdata_i;
        REG_ALPHA:    alpha_q    <= cfg_wdata_i[8:0];
        REG_ADC_FS:   adc_fs_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Hold sequencer state, level and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      lvl_q     <= LVL_NORMAL;
      prev_q    <= LVL_NORMAL;
      sv_q      <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      lvl_q     <= lvl_d;
      prev_q    <= prev_d;
      sv_q      <= sv_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    sample_q <= sample_d;
    nv_q     <= nv_d;
    acc_q    <= acc_d;
    rem_q    <= rem_d;
    den_q    <= den_d;
    quo_q    <= quo_d;
    cnt_q    <= cnt_d;
  end

  // Load the output register when the previous result has been taken
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_mv_q  <= sv_q[SV_W-1:8];
      out_pct_q <= (quo_q > 8'(PCT_MAX)) ? PCT_MAX : quo_q[6:0];
      out_lvl_q <= lvl_q;
      out_chg_q <= (lvl_q != prev_q);
    end
  end

  // Sequence one transaction through the shared multiplier and subtractor
  always_comb begin
    state_d  = state_q;
    lvl_d    = lvl_q;
    prev_d   = prev_q;
    sample_d = sample_q;
    sv_d     = sv_q;
    nv_d     = nv_q;
    acc_d    = acc_q;
    rem_d    = rem_q;
    den_d    = den_q;
    quo_d    = quo_q;
    cnt_d    = cnt_q;
    mul_a    = '0;
    mul_b    = '0;
    out_load = 1'b0;
    out_vld_d = out_vld_q && !m_axis_tready;

    unique case (state_q)
      ST_IDLE: begin
        if (in_hs) begin
          prev_d   = lvl_q;
          sample_d = s_axis_tdata[11:0];
          if (s_axis_tuser == KIND_SAMPLE) begin
            state_d = ST_SCALE;
          end else begin
            // Ignore the unused level code
            if (s_axis_tdata[13:12] != 2'd3) begin
              lvl_d = lvl_e'(s_axis_tdata[13:12]);
            end
            state_d = ST_PCT_SUB;
          end
        end
      end
      ST_SCALE: begin
        // sample * full_scale * 256 / 2^ADC_BITS, saturated to 24 bits
        mul_a = MUL_A_W'(sample_q);
        mul_b = adc_fs_q;
        nv_d  = (|scaled[MUL_P_W-1:SV_W]) ? SV_MAX : scaled[SV_W-1:0];
        state_d = ST_MIX_NEW;
      end
      ST_MIX_NEW: begin
        mul_a = nv_q;
        mul_b = MUL_B_W'(alpha_c);
        acc_d = mul_p[31:0];
        state_d = ST_MIX_OLD;
      end
      ST_MIX_OLD: begin
        mul_a = sv_q;
        mul_b = MUL_B_W'(ALPHA_ONE - alpha_c);
        acc_d = acc_q + mul_p[31:0];
        state_d = ST_CLASSIFY;
      end
      ST_CLASSIFY: begin
        sv_d = sv_new;
        if (sv_new <= {crit_thr_q, 8'd0}) begin
          lvl_d = LVL_CRIT;
        end else if (sv_new <= {low_thr_q, 8'd0}) begin
          lvl_d = LVL_LOW;
        end else begin
          lvl_d = LVL_NORMAL;
        end
        state_d = ST_PCT_SUB;
      end
      ST_PCT_SUB: begin
        // Percent reads zero for an empty band or a voltage at or below empty
        if ((full_mv_q <= empty_mv_q) || (sv_q <= empty_q8)) begin
          quo_d   = '0;
          state_d = ST_OUT;
        end else begin
          rem_d   = {8'd0, sv_q - empty_q8};
          den_d   = full_mv_q - empty_mv_q;
          state_d = ST_PCT_MUL;
        end
      end
      ST_PCT_MUL: begin
        mul_a = rem_q[SV_W-1:0];
        mul_b = MUL_B_W'(PCT_MAX);
        rem_d = mul_p[31:0];
        state_d = ST_DIV_CHK;
      end
      ST_DIV_CHK: begin
        // Quotient of 256 or more saturates straight away
        if (rem_q >= {den_q, 16'd0}) begin
          quo_d   = 8'(PCT_MAX);
          state_d = ST_OUT;
        end else begin
          quo_d   = '0;
          cnt_d   = 3'd7;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        // Restoring divide, one quotient bit a cycle
        if (rem_q >= div_sh) begin
          rem_d        = rem_q - div_sh;
          quo_d[cnt_q] = 1'b1;
        end
        cnt_d = cnt_q - 3'd1;
        if (cnt_q == 3'd0) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_vld_q || m_axis_tready) begin
          out_load  = 1'b1;
          out_vld_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'd0,
                          (out_lvl_q == LVL_CRIT),
                          (out_lvl_q != LVL_NORMAL),
                          out_chg_q,
                          out_lvl_q,
                          out_pct_q,
                          out_mv_q};

  // Accepted transaction keeps the sequencer busy on the next cycle
  `BLM_ASSERT(a_busy_after_accept, in_hs |=> (state_q != ST_IDLE), "idle right after accept")
  // Reported percentage stays within range
  `BLM_ASSERT(a_pct_range, out_vld_q |-> (out_pct_q <= PCT_MAX), "percent above 100")
  // Force transaction leaves the smoothed voltage alone
  `BLM_ASSERT(a_force_keeps_sv, (in_hs && (s_axis_tuser == KIND_FORCE)) |=> $stable(sv_q), "voltage moved on force")

endmodule

// File: sim/tb_battery_level_monitor.sv
// ----------------------------------------------------------------------------
// Battery level monitor testbench
// Drives sample and force transactions through the input stream and checks
// every output transaction against a cycle-free predictor of the monitor.
// A directed table covers thresholds, register extremes and ignored codes;
// random phases follow, each with fresh register settings and a random stall level
// for both streams; the last phase runs with no stalls.
// ----------------------------------------------------------------------------
module tb_battery_level_monitor;
  import blm_pkg::*;

  localparam int unsigned PHASES          = 16;
  localparam int unsigned ITEMS_PER_PHASE = 100;
  localparam int unsigned LONG_HOLD       = 400;
  localparam int unsigned DRAIN_LIMIT     = 2000;
  localparam int unsigned SETTLE_CYCLES   = 40;
  localparam int unsigned RUN_LIMIT       = 10_000_000;
  localparam int unsigned MAX_REPORTS     = 100;

  // Register indexes past the end of the map; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;
  // Forced state code with no level behind it
  localparam logic [1:0] FORCE_INVALID = 2'd3;

  // Output tdata layout, lowest field last
  typedef struct packed {
    logic [3:0]  fill;
    logic        crit;
    logic        low;
    logic        changed;
    logic [1:0]  level;
    logic [6:0]  pct;
    logic [15:0] mv;
  } batt_result_t;

  typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_e;

  typedef struct packed {
    row_kind_e            op;
    logic                 kind;
    logic [11:0]          adc;
    logic [1:0]           fst;
    logic [CFG_IDX_W-1:0] idx;
    logic [15:0]          val;
    logic                 typed;
    batt_result_t         res;
  } dir_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  // Predictor copy of the registers and the monitor state
  logic [15:0] low_thr_mv, crit_thr_mv, full_mv, empty_mv, adc_fs_mv;
  logic [8:0]  alpha_w;
  logic [23:0] smoothed_q8;
  lvl_e        level_now;

  batt_result_t  expected_results[$];
  dir_row_t      dir_rows[$];
  int unsigned   mismatches = 0;
  int unsigned   busy_level = 2;
  bit            hold_req = 1'b0;

  battery_level_monitor u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  // Raw reading to millivolts Q16.8, saturated to 24 bits
  function automatic logic [23:0] scale_to_mv_q8(logic [11:0] adc);
    logic [63:0] a, b, v;
    a = 64'(adc);
    b = 64'(adc_fs_mv);
    v = (a * b) << 8;
    v = v >> ADC_BITS;
    if (v > 64'hFF_FFFF) v = 64'hFF_FFFF;
    return v[23:0];
  endfunction

  function automatic logic [6:0] charge_pct(logic [23:0] sv);
    logic [63:0] e8, f8, s, p;
    e8 = 64'({empty_mv, 8'h00});
    f8 = 64'({full_mv, 8'h00});
    s  = 64'(sv);
    if (f8 <= e8 || s <= e8) return 7'd0;
    p = ((s - e8) * 64'd100) / (f8 - e8);
    return (p > 64'd100) ? PCT_MAX : p[6:0];
  endfunction

  // Advance the predicted state by one accepted transaction
  function automatic batt_result_t predict_item(logic kind, logic [11:0] adc,
                                                logic [1:0] fst);
    batt_result_t r;
    lvl_e         prev;
    logic [63:0]  a, mix;
    prev = level_now;
    if (kind == KIND_SAMPLE) begin
      a   = (alpha_w > ALPHA_ONE) ? 64'd256 : {55'd0, alpha_w};
      mix = a * 64'(scale_to_mv_q8(adc)) + (64'd256 - a) * 64'(smoothed_q8);
      smoothed_q8 = mix[31:8];
      if (smoothed_q8 <= {crit_thr_mv, 8'h00})
        level_now = LVL_CRIT;
      else if (smoothed_q8 <= {low_thr_mv, 8'h00})
        level_now = LVL_LOW;
      else
        level_now = LVL_NORMAL;
    end else if (fst != FORCE_INVALID) begin
      level_now = lvl_e'(fst);
    end
    r.fill    = 4'd0;
    r.mv      = smoothed_q8[23:8];
    r.pct     = charge_pct(smoothed_q8);
    r.level   = level_now;
    r.changed = (level_now != prev);
    r.low     = (level_now != LVL_NORMAL);
    r.crit    = (level_now == LVL_CRIT);
    return r;
  endfunction

  // ----------------------------------------------------------- directed table

  function automatic void add_item(logic kind, logic [11:0] adc, logic [1:0] fst);
    dir_row_t row;
    row       = '0;
    row.op    = ROW_ITEM;
    row.kind  = kind;
    row.adc   = adc;
    row.fst   = fst;
    dir_rows.push_back(row);
  endfunction

  function automatic void add_typed(logic kind, logic [11:0] adc, logic [1:0] fst,
                                    logic [15:0] mv, logic [6:0] pct, lvl_e level,
                                    logic changed);
    dir_row_t row;
    row             = '0;
    row.op          = ROW_ITEM;
    row.kind        = kind;
    row.adc         = adc;
    row.fst         = fst;
    row.typed       = 1'b1;
    row.res.mv      = mv;
    row.res.pct     = pct;
    row.res.level   = level;
    row.res.changed = changed;
    row.res.low     = (level != LVL_NORMAL);
    row.res.crit    = (level == LVL_CRIT);
    dir_rows.push_back(row);
  endfunction

  function automatic void add_write(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    dir_row_t row;
    row     = '0;
    row.op  = ROW_WRITE;
    row.idx = idx;
    row.val = val;
    dir_rows.push_back(row);
  endfunction

  // --------------------------------------------------------------- stimulus

  function automatic logic [15:0] pick_mv(int unsigned lo, int unsigned hi);
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(lo, hi));
    endcase
  endfunction

  function automatic logic [15:0] pick_alpha();
    case ($urandom_range(0, 7))
      0:       return 16'd0;
      1:       return 16'(ALPHA_ONE);
      2:       return 16'($urandom_range(257, 511));
      default: return 16'($urandom_range(1, 255));
    endcase
  endfunction

  function automatic logic [11:0] pick_adc();
    case ($urandom_range(0, 7))
      0:       return 12'd0;
      1:       return 12'hFFF;
      2, 3:    return 12'($urandom_range(0, 4095));
      default: return 12'($urandom_range(1400, 2700));
    endcase
  endfunction

  // Present one transaction and hold it until accepted
  task automatic offer_item(logic kind, logic [11:0] adc, logic [1:0] fst,
                            logic typed, batt_result_t typed_res);
    batt_result_t r;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {2'b00, fst, adc};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    r = predict_item(kind, adc, fst);
    expected_results.push_back(typed ? typed_res : r);
  endtask

  task automatic sender_gap();
    int unsigned n;
    if (busy_level != 0 && $urandom_range(0, 7) < busy_level) begin
      n = $urandom_range(1, 18);
      repeat (n) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
      end
    end
  endtask

  // Drop valid and wait until every expected transaction has come out
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      REG_LOW_THR:  low_thr_mv  = val;
      REG_CRIT_THR: crit_thr_mv = val;
      REG_FULL_MV:  full_mv     = val;
      REG_EMPTY_MV: empty_mv    = val;
      REG_ALPHA:    alpha_w     = val[8:0];
      REG_ADC_FS:   adc_fs_mv   = val;
      default: ;
    endcase
  endtask

  initial begin : stimulus
    int unsigned  ph, i, n;
    logic         kind;
    batt_result_t none;

    none          = '0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = KIND_SAMPLE;

    low_thr_mv  = RST_LOW_THR;
    crit_thr_mv = RST_CRIT_THR;
    full_mv     = RST_FULL_MV;
    empty_mv    = RST_EMPTY_MV;
    alpha_w     = RST_ALPHA;
    adc_fs_mv   = RST_ADC_FS;
    smoothed_q8 = '0;
    level_now   = LVL_NORMAL;

    // From reset: zero reading is critical, then walk the forced states
    add_typed(KIND_SAMPLE, 12'd0,   FORCE_INVALID, 16'd0, 7'd0, LVL_CRIT,   1'b1);
    add_typed(KIND_FORCE,  12'hFFF, LVL_NORMAL,    16'd0, 7'd0, LVL_NORMAL, 1'b1);
    add_typed(KIND_FORCE,  12'hA5A, FORCE_INVALID, 16'd0, 7'd0, LVL_NORMAL, 1'b0);
    add_typed(KIND_FORCE,  12'd0,   LVL_CRIT,      16'd0, 7'd0, LVL_CRIT,   1'b1);
    add_typed(KIND_FORCE,  12'd0,   LVL_CRIT,      16'd0, 7'd0, LVL_CRIT,   1'b0);
    add_typed(KIND_FORCE,  12'h5A5, LVL_LOW,       16'd0, 7'd0, LVL_LOW,    1'b1);
    // Full-scale readings under the default smoothing
    add_item(KIND_SAMPLE, 12'hFFF, LVL_LOW);
    add_item(KIND_SAMPLE, 12'hFFF, LVL_NORMAL);
    // No smoothing and one millivolt per count: threshold boundaries
    add_write(REG_ALPHA, 16'(ALPHA_ONE));
    add_write(REG_ADC_FS, 16'd4096);
    add_typed(KIND_SAMPLE, 12'd3000, LVL_NORMAL, 16'd3000, 7'd0,  LVL_CRIT,   1'b0);
    add_typed(KIND_SAMPLE, 12'd3001, LVL_NORMAL, 16'd3001, 7'd0,  LVL_LOW,    1'b1);
    add_typed(KIND_SAMPLE, 12'd3300, LVL_NORMAL, 16'd3300, 7'd25, LVL_LOW,    1'b0);
    add_typed(KIND_SAMPLE, 12'd3301, LVL_NORMAL, 16'd3301, 7'd25, LVL_NORMAL, 1'b1);
    add_item(KIND_SAMPLE, 12'hFFF, LVL_CRIT);
    // Largest scale gives the largest voltage; percent clamps
    add_write(REG_ADC_FS, 16'hFFFF);
    add_item(KIND_SAMPLE, 12'hFFF, LVL_NORMAL);
    // Full equal to empty reads zero percent
    add_write(REG_FULL_MV, 16'd3000);
    add_item(KIND_SAMPLE, 12'hFFF, LVL_NORMAL);
    // Zero alpha holds the voltage; alpha past one behaves as one
    add_write(REG_ALPHA, 16'd0);
    add_item(KIND_SAMPLE, 12'd0, LVL_NORMAL);
    add_write(REG_ALPHA, 16'd300);
    add_item(KIND_SAMPLE, 12'd1000, LVL_NORMAL);
    // Writes past the register map change nothing
    add_write(REG_SPARE_6, 16'hFFFF);
    add_write(REG_SPARE_7, 16'h0000);
    // Threshold extremes
    add_write(REG_LOW_THR, 16'hFFFF);
    add_write(REG_CRIT_THR, 16'd0);
    add_item(KIND_SAMPLE, 12'hFFF, LVL_NORMAL);
    add_item(KIND_SAMPLE, 12'd0, LVL_NORMAL);
    add_write(REG_FULL_MV, 16'hFFFF);
    add_write(REG_EMPTY_MV, 16'd0);
    add_item(KIND_FORCE, 12'd0, LVL_NORMAL);
    add_item(KIND_SAMPLE, 12'hFFF, LVL_NORMAL);

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Walk the directed table
    foreach (dir_rows[r]) begin
      if (dir_rows[r].op == ROW_WRITE) begin
        drain_results();
        write_reg(dir_rows[r].idx, dir_rows[r].val);
      end else begin
        offer_item(dir_rows[r].kind, dir_rows[r].adc, dir_rows[r].fst,
                   dir_rows[r].typed, dir_rows[r].res);
        sender_gap();
      end
    end

    // Random phases, each with a fresh register setting
    for (ph = 0; ph < PHASES; ph++) begin
      drain_results();
      write_reg(REG_LOW_THR,  pick_mv(3000, 3800));
      write_reg(REG_CRIT_THR, pick_mv(2600, 3400));
      write_reg(REG_FULL_MV,  pick_mv(3600, 4500));
      write_reg(REG_EMPTY_MV, pick_mv(2500, 3500));
      write_reg(REG_ALPHA,    pick_alpha());
      write_reg(REG_ADC_FS,   pick_mv(4000, 8000));
      if ($urandom_range(0, 3) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7, 16'($urandom));
      busy_level = (ph == PHASES - 1) ? 0 : $urandom_range(0, 3);
      for (i = 0; i < ITEMS_PER_PHASE; i++) begin
        // Stall the output for a long stretch while input keeps coming
        if (ph == 3 && i == 10) hold_req = 1'b1;
        // Let the monitor run dry in the middle of a phase
        if (ph == 6 && i == 50) drain_results();
        kind = ($urandom_range(0, 3) == 0) ? KIND_FORCE : KIND_SAMPLE;
        offer_item(kind, pick_adc(), 2'($urandom_range(0, 3)), 1'b0, none);
        sender_gap();
      end
    end

    // Wait out the remaining transactions, then let the outputs settle
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    for (n = 0; n < DRAIN_LIMIT && expected_results.size() != 0; n++) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $display("%0t: %0d expected transactions never arrived", $time,
               expected_results.size());
      mismatches++;
    end
    if (mismatches == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  // ---------------------------------------------------------------- receiver

  initial begin : receiver
    int unsigned n;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
        m_axis_tready <= 1'b1;
      end else if (busy_level != 0 && $urandom_range(0, 7) < busy_level) begin
        n = $urandom_range(1, 18);
        m_axis_tready <= 1'b0;
        repeat (n) @(negedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // ----------------------------------------------------------------- checker

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      if (mismatches < MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Compare each output transaction with the oldest expectation
  always @(posedge clk_i) begin : check_out
    batt_result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (expected_results.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("%0t: unexpected transaction, expected none, actual %h", $time,
                   m_axis_tdata);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("voltage_mv",       want.mv,               got.mv);
        check_field("percent",          16'(want.pct),         16'(got.pct));
        check_field("power_state",      16'(want.level),       16'(got.level));
        check_field("state_changed",    16'(want.changed),     16'(got.changed));
        check_field("battery_low",      16'(want.low),         16'(got.low));
        check_field("battery_critical", 16'(want.crit),        16'(got.crit));
        check_field("tdata fill",       16'(want.fill),        16'(got.fill));
      end
    end
  end

  initial begin : watchdog
    #(RUN_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/blm_pkg.sv
rtl/core/battery_level_monitor.sv
sim/tb_battery_level_monitor.sv
